[hw/rtl/fsmff_pkg.sv]
// Shared types, constants and helpers for the free-space map core.
// No dependencies; imported by every module of the block.
`default_nettype none

package fsmff_pkg;

    localparam int NIB_W             = 4;
    localparam int NIBBLES           = 16;
    localparam int SLOT_W            = 4;
    localparam int WORD_W            = NIB_W * NIBBLES;
    localparam int PAGE_PORT_W       = 13;
    localparam int COUNT_PORT_W      = 14;
    localparam int DEFAULT_MAX_PAGES = 8192;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic [NIB_W-1:0] FULL_LEVEL_RESET = 4'd15;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_SET   = 2'd1,
        OP_READ  = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    // first-fit outcome for one memory word
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [NIB_W-1:0]  sum;
    } fit_t;

    function automatic logic [WORD_W-1:0] put_nibble(
        input logic [WORD_W-1:0] word,
        input logic [SLOT_W-1:0] slot,
        input logic [NIB_W-1:0]  val
    );
        logic [WORD_W-1:0] w;
        w = word;
        for (int j = 0; j < NIBBLES; j++)
        begin
            if (slot == SLOT_W'(j))
            begin
                w[j*NIB_W +: NIB_W] = val;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/free_space_map_first_fit_core.sv]
// Free-space map with first-fit allocation: level memory, sequencer, APB register.
// Depends on fsmff_pkg and fsmff_fit_check.
//
//  channel | direction | handshake             | beat contents
//  --------+-----------+-----------------------+---------------------------------------
//  in      | in        | in_valid / in_stall   | op, page_index, level, page_count
//  out     | out       | out_valid / out_stall | result_page, result_level, ok
//  apb     | in        | psel/penable/pready   | full_level at byte address 0
//
// One beat at a time. Set and read go through the read, write and done states to the
// output register; allocate scans the words in use, then appends a page when none fits;
// the scan reads one 64-bit word (sixteen pages) per cycle from the map RAM.
// Initialize and reset both run a clearing pass over all ceil(MAX_PAGES/16) words
// (512 at the default size); no input beat is taken during it.
// The result register lets a new beat be accepted while the last result is stalled.
`default_nettype none

module free_space_map_first_fit_core
    import fsmff_pkg::*;
#(
    parameter int MAX_PAGES = DEFAULT_MAX_PAGES
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              op,
    input  logic [PAGE_PORT_W-1:0]  page_index,
    input  logic [NIB_W-1:0]        level,
    input  logic [COUNT_PORT_W-1:0] page_count,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PAGE_PORT_W-1:0]  result_page,
    output logic [NIB_W-1:0]        result_level,
    output logic                    ok
);

    localparam int WORDS = (MAX_PAGES + NIBBLES - 1) / NIBBLES;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);

    localparam logic REG_FULL_LEVEL = 1'b0;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_ONE_RD = 6'b001000,
        ST_ONE_WR = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [WA_W-1:0]         clr_ptr_reg, clr_ptr_next;
    logic                    clr_res_reg, clr_res_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [NIB_W-1:0]        full_level_reg, full_level_next;
    logic [CNT_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                    pend_reg;
    logic                    out_valid_reg, out_valid_next;

    op_t                     op_reg, op_next;
    logic [NIB_W-1:0]        lvl_reg, lvl_next;
    logic [PAGE_PORT_W-1:0]  page_reg, page_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [WA_W-1:0]         addr_reg, addr_next;
    logic [WA_W-1:0]         chk_word_reg, chk_word_next;
    logic [PAGE_PORT_W-1:0]  res_page_reg, res_page_next;
    logic [NIB_W-1:0]        res_level_reg, res_level_next;
    logic                    res_ok_reg, res_ok_next;
    logic [PAGE_PORT_W-1:0]  out_page_reg, out_page_next;
    logic [NIB_W-1:0]        out_level_reg, out_level_next;
    logic                    out_ok_reg, out_ok_next;

    logic [WORD_W-1:0]       mem [WORDS];
    logic [WORD_W-1:0]       rd_data_reg;
    logic                    rd_en;
    logic [WA_W-1:0]         rd_addr;
    logic                    mem_we;
    logic [WA_W-1:0]         mem_wa;
    logic [WORD_W-1:0]       mem_wd;

    logic [CNT_W:0]          used_plus;
    logic [CNT_W-1:0]        nwords;
    logic                    issue;
    logic [CNT_W-1:0]        chk_ext;
    logic [CNT_W-1:0]        full_words;
    logic [SLOT_W-1:0]       used_rem;
    logic [NIBBLES-1:0]      slot_used;
    logic                    page_in_map;
    logic                    used_lt_max;
    logic [CNT_W-1:0]        cnt_sat;
    logic [NIB_W-1:0]        rd_nib;
    logic                    cfg_wr;
    fit_t                    fit;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FULL_LEVEL);
    assign prdata = (paddr[2] == REG_FULL_LEVEL) ? CFG_DATA_W'(full_level_reg) : '0;
    assign full_level_next = cfg_wr ? pwdata[NIB_W-1:0] : full_level_reg;

    // ---------------- level map RAM ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------- scan bookkeeping ----------------
    assign used_plus  = {1'b0, used_reg} + (CNT_W+1)'(NIBBLES - 1);
    assign nwords     = CNT_W'(used_plus >> SLOT_W);
    assign issue      = (rd_ptr_reg < nwords);
    assign chk_ext    = CNT_W'(chk_word_reg);
    assign full_words = used_reg >> SLOT_W;
    assign used_rem   = used_reg[SLOT_W-1:0];

    // only slots below the page count take part in the search
    always_comb
    begin
        for (int j = 0; j < NIBBLES; j++)
        begin
            if (chk_ext < full_words)
            begin
                slot_used[j] = 1'b1;
            end
            else if (chk_ext == full_words)
            begin
                slot_used[j] = (SLOT_W'(j) < used_rem);
            end
            else
            begin
                slot_used[j] = 1'b0;
            end
        end
    end

    fsmff_fit_check u_fit (
        .word       (rd_data_reg),
        .slot_used  (slot_used),
        .req_level  (lvl_reg),
        .full_level (full_level_reg),
        .fit        (fit)
    );

    assign page_in_map = (32'(page_index) < 32'(MAX_PAGES));
    assign used_lt_max = (32'(used_reg) < 32'(MAX_PAGES));
    assign cnt_sat     = (32'(page_count) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                            : CNT_W'(page_count);
    assign rd_nib      = rd_data_reg[slot_reg*NIB_W +: NIB_W];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        clr_res_next   = clr_res_reg;
        used_next      = used_reg;
        rd_ptr_next    = rd_ptr_reg;
        op_next        = op_reg;
        lvl_next       = lvl_reg;
        page_next      = page_reg;
        slot_next      = slot_reg;
        addr_next      = addr_reg;
        chk_word_next  = chk_word_reg;
        res_page_next  = res_page_reg;
        res_level_next = res_level_reg;
        res_ok_next    = res_ok_reg;
        out_page_next  = out_page_reg;
        out_level_next = out_level_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && out_stall;

        rd_en   = 1'b0;
        rd_addr = rd_ptr_reg[WA_W-1:0];
        mem_we  = 1'b0;
        mem_wa  = clr_ptr_reg;
        mem_wd  = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_ptr_reg == WA_W'(WORDS - 1))
                begin
                    clr_ptr_next = '0;
                    if (clr_res_reg)
                    begin
                        res_page_next  = '0;
                        res_level_next = '0;
                        res_ok_next    = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(op);
                    lvl_next    = level;
                    page_next   = page_index;
                    slot_next   = page_index[SLOT_W-1:0];
                    addr_next   = WA_W'(page_index >> SLOT_W);
                    rd_ptr_next = '0;
                    case (op_t'(op))
                        OP_ALLOC:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_SET, OP_READ:
                        begin
                            if (page_in_map)
                            begin
                                state_next = ST_ONE_RD;
                            end
                            else
                            begin
                                res_page_next  = page_index;
                                res_level_next = '0;
                                res_ok_next    = 1'b0;
                                state_next     = ST_DONE;
                            end
                        end
                        OP_INIT:
                        begin
                            used_next    = cnt_sat;
                            clr_res_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // reads run one word ahead of the check
                rd_en = issue;
                if (issue)
                begin
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                    chk_word_next = rd_ptr_reg[WA_W-1:0];
                end
                if (pend_reg && fit.hit)
                begin
                    mem_we         = 1'b1;
                    mem_wa         = chk_word_reg;
                    mem_wd         = put_nibble(rd_data_reg, fit.slot, fit.sum);
                    res_page_next  = PAGE_PORT_W'({chk_word_reg, fit.slot});
                    res_level_next = fit.sum;
                    res_ok_next    = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (!issue)
                begin
                    if (used_lt_max)
                    begin
                        addr_next  = WA_W'(used_reg >> SLOT_W);
                        slot_next  = used_reg[SLOT_W-1:0];
                        state_next = ST_ONE_RD;
                    end
                    else
                    begin
                        res_page_next  = '0;
                        res_level_next = '0;
                        res_ok_next    = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end

            ST_ONE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_reg;
                state_next = ST_ONE_WR;
            end

            ST_ONE_WR:
            begin
                res_ok_next = 1'b1;
                state_next  = ST_DONE;
                case (op_reg)
                    OP_READ:
                    begin
                        res_page_next  = page_reg;
                        res_level_next = rd_nib;
                    end
                    OP_SET:
                    begin
                        mem_we         = 1'b1;
                        mem_wa         = addr_reg;
                        mem_wd         = put_nibble(rd_data_reg, slot_reg, lvl_reg);
                        res_page_next  = page_reg;
                        res_level_next = lvl_reg;
                    end
                    default:
                    begin
                        // append a fresh page after the scan found no room
                        mem_we         = 1'b1;
                        mem_wa         = addr_reg;
                        mem_wd         = put_nibble(rd_data_reg, slot_reg, lvl_reg);
                        res_page_next  = PAGE_PORT_W'(used_reg);
                        res_level_next = lvl_reg;
                        used_next      = used_reg + 1'b1;
                    end
                endcase
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_page_next  = res_page_reg;
                    out_level_next = res_level_reg;
                    out_ok_next    = res_ok_reg;
                    clr_res_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_ptr_reg    <= '0;
            clr_res_reg    <= 1'b0;
            used_reg       <= '0;
            full_level_reg <= FULL_LEVEL_RESET;
            rd_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            clr_res_reg    <= clr_res_next;
            used_reg       <= used_next;
            full_level_reg <= full_level_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_reg       <= rd_en;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        lvl_reg       <= lvl_next;
        page_reg      <= page_next;
        slot_reg      <= slot_next;
        addr_reg      <= addr_next;
        chk_word_reg  <= chk_word_next;
        res_page_reg  <= res_page_next;
        res_level_reg <= res_level_next;
        res_ok_reg    <= res_ok_next;
        out_page_reg  <= out_page_next;
        out_level_reg <= out_level_next;
        out_ok_reg    <= out_ok_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_page  = out_page_reg;
    assign result_level = out_level_reg;
    assign ok           = out_ok_reg;

    // ---------------- assertions ----------------
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(MAX_PAGES))
        else $error("page count beyond map size");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && rd_en && (mem_wa == rd_addr)))
        else $error("map read and write hit the same word in one cycle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result register loaded outside the done state");

endmodule

`default_nettype wire

[hw/rtl/fsmff_fit_check.sv]
// First-fit search across the sixteen fill levels of one map word.
// Depends on fsmff_pkg (widths, fit_t).
`default_nettype none

module fsmff_fit_check
    import fsmff_pkg::*;
(
    input  logic [WORD_W-1:0]  word,
    input  logic [NIBBLES-1:0] slot_used,
    input  logic [NIB_W-1:0]   req_level,
    input  logic [NIB_W-1:0]   full_level,
    output fit_t               fit
);

    always_comb
    begin
        logic [NIB_W:0] sum;
        fit = '0;
        // walk downward so the lowest fitting slot wins
        for (int j = NIBBLES - 1; j >= 0; j--)
        begin
            sum = {1'b0, word[j*NIB_W +: NIB_W]} + {1'b0, req_level};
            if (slot_used[j] && (sum <= {1'b0, full_level}))
            begin
                fit.hit  = 1'b1;
                fit.slot = SLOT_W'(j);
                fit.sum  = sum[NIB_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire
